/* hdl/pqk_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqk_pkg: shared types and constants for the process queue
// Widths, operation and status codes, and the request and result records
// passed between the front end, the back end and the top level.
// ----------------------------------------------------------------------------
package pqk_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int OCC_W    = $clog2(CAPACITY + 1);
  localparam int COUNT_W  = 5;
  localparam int ID_W     = 16;
  localparam int HND_W    = 16;
  localparam int Q_DEPTH  = 2;
  localparam int QPTR_W   = $clog2(Q_DEPTH);
  localparam int QCNT_W   = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_FIND   = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } bk_state_t;

  typedef struct packed {
    op_t              op;
    logic [ID_W-1:0]  key;
    logic [HND_W-1:0] hnd;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [HND_W-1:0]   handle;
    logic               empty;
    logic [COUNT_W-1:0] count;
  } res_t;

endpackage

/* hdl/pqk_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqk_front: request intake and decode
// Accepts requests, decodes the command code and holds them in a short
// queue until the back end is ready to carry them out.
// ----------------------------------------------------------------------------
module pqk_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [1:0]                 in_tuser,
  input  logic [31:0]                in_tdata,
  output logic                       q_valid,
  input  logic                       q_pop,
  output pqk_pkg::req_t              q_req
);

  pqk_pkg::req_t                   slot_r [pqk_pkg::Q_DEPTH];
  logic [pqk_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [pqk_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [pqk_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;
  logic                            push;
  pqk_pkg::req_t                   dec;

  // Decode the incoming request into the internal record.
  always_comb begin
    dec.op  = pqk_pkg::op_t'(in_tuser);
    dec.key = in_tdata[15:0];
    dec.hnd = in_tdata[31:16];
  end

  assign in_tready = (cnt_r != pqk_pkg::QCNT_W'(pqk_pkg::Q_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign q_req     = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == pqk_pkg::QPTR_W'(pqk_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == pqk_pkg::QPTR_W'(pqk_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= dec;
    end
  end

endmodule

/* hdl/pqk_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqk_back: entry cells and command execution
// Holds the ordered entries in a row of cells, matches the key against all
// of them at once, then from the registered match pushes, shifts out or reports.
// ----------------------------------------------------------------------------
module pqk_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_pop,
  input  pqk_pkg::req_t q_req,
  output logic          res_valid,
  input  logic          res_ready,
  output pqk_pkg::res_t res
);

  localparam int CAP = pqk_pkg::CAPACITY;

  logic [pqk_pkg::ID_W-1:0]  ids_r  [CAP];
  logic [pqk_pkg::HND_W-1:0] hnds_r [CAP];
  logic [pqk_pkg::OCC_W-1:0] occ_r, occ_nxt;

  pqk_pkg::bk_state_t state_r, state_nxt;
  pqk_pkg::req_t      req_r;
  logic [CAP-1:0]     first_r, shift_r;
  logic               hit_r;

  logic               res_valid_r, res_valid_nxt;
  pqk_pkg::res_t      res_r, res_nxt;

  logic [CAP-1:0]            match, first_c, shift_c;
  logic                      seen;
  logic                      exec, full, do_push, do_take;
  logic [pqk_pkg::HND_W-1:0] sel_hnd;

  // Match every live cell against the key (for pop, the head cell if any); keep
  // the oldest hit and the mask of cells at or after it, the ones that shift on removal.
  always_comb begin
    match = '0;
    if (q_req.op == pqk_pkg::OP_POP) begin
      match[0] = (occ_r != '0);
    end else begin
      for (int i = 0; i < CAP; i++) begin
        match[i] = (pqk_pkg::OCC_W'(i) < occ_r) && (ids_r[i] == q_req.key);
      end
    end
    seen    = 1'b0;
    first_c = '0;
    shift_c = '0;
    for (int i = 0; i < CAP; i++) begin
      first_c[i] = match[i] && !seen;
      seen       = seen || match[i];
      shift_c[i] = seen;
    end
  end

  always_comb begin
    sel_hnd = '0;
    for (int i = 0; i < CAP; i++) begin
      sel_hnd = sel_hnd | (hnds_r[i] & {pqk_pkg::HND_W{first_r[i]}});
    end
  end

  assign exec    = (state_r == pqk_pkg::BK_EXEC);
  assign full    = (occ_r == pqk_pkg::OCC_W'(CAP));
  assign do_push = exec && (req_r.op == pqk_pkg::OP_PUSH) && !full;
  assign do_take = exec && hit_r &&
                   ((req_r.op == pqk_pkg::OP_POP) || (req_r.op == pqk_pkg::OP_REMOVE));

  always_comb begin
    state_nxt     = state_r;
    q_pop         = 1'b0;
    occ_nxt       = occ_r;
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r && !res_ready;
    case (state_r)
      pqk_pkg::BK_IDLE: begin
        // Start only when the result register is free by the time we finish.
        if (q_valid && (!res_valid_r || res_ready)) begin
          q_pop     = 1'b1;
          state_nxt = pqk_pkg::BK_EXEC;
        end
      end
      pqk_pkg::BK_EXEC: begin
        if (do_push) begin
          occ_nxt = occ_r + 1'b1;
        end else if (do_take) begin
          occ_nxt = occ_r - 1'b1;
        end
        if (req_r.op == pqk_pkg::OP_PUSH) begin
          res_nxt.status = full ? pqk_pkg::ST_FULL : pqk_pkg::ST_OK;
          res_nxt.handle = '0;
        end else begin
          res_nxt.status = hit_r ? pqk_pkg::ST_OK : pqk_pkg::ST_MISS;
          res_nxt.handle = sel_hnd;
        end
        res_nxt.empty  = (occ_nxt == '0);
        res_nxt.count  = pqk_pkg::COUNT_W'(occ_nxt);
        res_valid_nxt  = 1'b1;
        state_nxt      = pqk_pkg::BK_IDLE;
      end
      default: begin
        state_nxt = pqk_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pqk_pkg::BK_IDLE;
      occ_r       <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (q_pop) begin
      req_r   <= q_req;
      first_r <= first_c;
      shift_r <= shift_c;
      hit_r   <= |match;
    end
  end

  // Entry cells: push writes at the tail, removal shifts younger cells down.
  always_ff @(posedge clk) begin
    if (do_push) begin
      ids_r[occ_r[pqk_pkg::IDX_W-1:0]]  <= req_r.key;
      hnds_r[occ_r[pqk_pkg::IDX_W-1:0]] <= req_r.hnd;
    end else if (do_take) begin
      for (int i = 0; i < CAP - 1; i++) begin
        if (shift_r[i]) begin
          ids_r[i]  <= ids_r[i + 1];
          hnds_r[i] <= hnds_r[i + 1];
        end
      end
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

/* hdl/process_queue_with_keyed_removal.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// process_queue_with_keyed_removal: ordered process queue with keyed removal
// Up to sixteen entries of process id and handle, kept oldest first. Push,
// pop head, remove by id and find by id; one result for every request.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  tdata (lowest bit first)                 tuser
//  in_      request    proc_id[15:0], handle[31:16]             cmd[1:0]
//  out_     result     out_handle[15:0], is_empty[16],          status[1:0]
//                      count[21:17], zero pad[23:22]
//
// In the back end each request is first compared with every entry cell at once
// to pick the oldest match; then the entry is pushed, the younger entries are
// shifted down or the result is reported. The back end does not take a new
// request until it has finished the one before.
// A two-request queue in front lets new requests be accepted while the back
// end works or while a result waits in the output register.
// Reset is synchronous and active low; it empties the queue at once. Entry
// storage is not cleared, as only entries below the count are ever read.
// A stalled result holds the back end, and the front queue then fills.
// ----------------------------------------------------------------------------
module process_queue_with_keyed_removal (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // proc_id[15:0], handle[31:16]
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // out_handle[15:0], is_empty[16], count[21:17]
  output logic [1:0]  out_tuser   // status[1:0]
);

  // Link between the front queue and the back end.
  logic          q_valid;
  logic          q_pop;
  pqk_pkg::req_t q_req;

  // Result record from the back end's output register.
  pqk_pkg::res_t res;

  // The front end decodes each request and queues it.
  pqk_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_req     (q_req)
  );

  // The back end holds the entries and carries out one request at a time.
  pqk_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_req     (q_req),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  // Pack the result; the top two bits are padding to a whole byte.
  assign out_tdata = {2'b00, res.count, res.empty, res.handle};
  assign out_tuser = res.status;

`ifndef SYNTHESIS
  // A refused push can only happen with the queue holding every entry.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == pqk_pkg::ST_FULL) |->
      (out_tdata[21:17] == pqk_pkg::COUNT_W'(pqk_pkg::CAPACITY)))
    else $error("full status reported with queue not full");

  // A miss or a refused push never carries a handle.
  a_miss_handle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != pqk_pkg::ST_OK) |-> (out_tdata[15:0] == 16'd0))
    else $error("handle returned on a failed request");

  // The empty flag agrees with the count.
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[16] == (out_tdata[21:17] == 5'd0)))
    else $error("empty flag disagrees with count");

  // A miss reported with a count of zero also shows the empty flag.
  a_pop_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == pqk_pkg::ST_MISS) && (out_tdata[21:17] == 5'd0) |->
      out_tdata[16])
    else $error("miss with zero count but not empty");
`endif

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the process queue with keyed removal
// Drives push, pop head, remove by id and find by id requests through the
// input stream, keeps a shadow copy of the queue to predict each result and
// compares every result field with the prediction, oldest first. A directed
// table covers the empty and full corners, followed by random traffic.
// ----------------------------------------------------------------------------
module tb;
  import pqk_pkg::*;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int LONG_STALL     = 300;
  localparam int ITEMS_PER_PASS = 570;
  localparam int DRAIN_CYCLES   = 12;

  typedef struct {
    op_t                op;
    logic [ID_W-1:0]    id;
    logic [HND_W-1:0]   hnd;
    bit                 typed;
    logic [1:0]         status;
    logic [HND_W-1:0]   handle;
    logic               empty;
    logic [COUNT_W-1:0] count;
  } directed_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // proc_id[15:0], handle[31:16]
  logic [1:0]  in_tuser;   // cmd[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // out_handle[15:0], is_empty[16], count[21:17]
  logic [1:0]  out_tuser;  // status[1:0]

  // Shadow of the queue contents, oldest entry at index zero.
  logic [ID_W-1:0]  shadow_ids[$];
  logic [HND_W-1:0] shadow_handles[$];

  // Results still owed by the block, in request order.
  res_t results_due[$];

  int fault_count;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;
  int stall_requests;
  int op_tally[4];
  int status_tally[4];
  int results_checked;

  process_queue_with_keyed_removal uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // The run is abandoned if it overruns; the limit is several times the
  // slowest legal run, including the long hold-off on the result side.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Applies one request to the shadow queue and returns what the block must
  // report for it. Remove and find act on the oldest entry with that id.
  function automatic res_t predict_queue_result(op_t op, logic [ID_W-1:0] id,
                                                logic [HND_W-1:0] hnd);
    res_t r;
    int   pos;
    r.status = ST_MISS;
    r.handle = '0;
    pos = -1;
    if (op == OP_REMOVE || op == OP_FIND) begin
      for (int i = 0; i < shadow_ids.size(); i++) begin
        if (pos < 0 && shadow_ids[i] == id) pos = i;
      end
    end
    case (op)
      OP_PUSH: begin
        if (shadow_ids.size() >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          shadow_ids.push_back(id);
          shadow_handles.push_back(hnd);
          r.status = ST_OK;
        end
      end
      OP_POP: begin
        if (shadow_ids.size() > 0) begin
          r.handle = shadow_handles.pop_front();
          void'(shadow_ids.pop_front());
          r.status = ST_OK;
        end
      end
      OP_REMOVE: begin
        if (pos >= 0) begin
          r.handle = shadow_handles[pos];
          shadow_ids.delete(pos);
          shadow_handles.delete(pos);
          r.status = ST_OK;
        end
      end
      default: begin
        if (pos >= 0) begin
          r.handle = shadow_handles[pos];
          r.status = ST_OK;
        end
      end
    endcase
    r.empty = (shadow_ids.size() == 0);
    r.count = COUNT_W'(shadow_ids.size());
    return r;
  endfunction

  // Offers one request, with random idle cycles in front of it, and records
  // the expected result once the block has taken it. Each falling edge
  // carries at most one assignment to the valid line.
  task automatic offer_request(op_t op, logic [ID_W-1:0] id, logic [HND_W-1:0] hnd,
                               bit typed, res_t typed_res);
    res_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {hnd, id};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    predicted = predict_queue_result(op, id, hnd);
    results_due.push_back(typed ? typed_res : predicted);
    op_tally[op]++;
  endtask

  // Picks an id: for searches mostly one that is in the queue, otherwise
  // a small pool that breeds duplicates, the top of the range or anything.
  function automatic logic [ID_W-1:0] pick_id(bit for_search);
    if (for_search && shadow_ids.size() > 0 && $urandom_range(99) < 65)
      return shadow_ids[$urandom_range(shadow_ids.size() - 1)];
    case ($urandom_range(3))
      0:       return ID_W'($urandom_range(7));
      1:       return ID_W'(16'hFFF8 + $urandom_range(7));
      default: return ID_W'($urandom);
    endcase
  endfunction

  // Result side: random back-pressure, and a long hold-off whenever the
  // stimulus asks for one, counted down here.
  initial begin : result_sink
    int stall_seen;
    int stall_left;
    stall_seen = 0;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_requests != stall_seen) begin
        stall_seen = stall_requests;
        stall_left = LONG_STALL;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Every accepted result is checked against the oldest one still owed.
  always @(posedge clk) begin
    res_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (results_due.size() == 0) begin
        $error("unexpected result: status %0d handle %h", out_tuser, out_tdata[15:0]);
        fault_count++;
      end else begin
        exp_res = results_due.pop_front();
        results_checked++;
        status_tally[out_tuser]++;
        if (out_tuser !== exp_res.status) begin
          $error("status: expected %0d, actual %0d", exp_res.status, out_tuser);
          fault_count++;
        end
        if (out_tdata[15:0] !== exp_res.handle) begin
          $error("out_handle: expected %h, actual %h", exp_res.handle, out_tdata[15:0]);
          fault_count++;
        end
        if (out_tdata[16] !== exp_res.empty) begin
          $error("is_empty: expected %0d, actual %0d", exp_res.empty, out_tdata[16]);
          fault_count++;
        end
        if (out_tdata[21:17] !== exp_res.count) begin
          $error("count: expected %0d, actual %0d", exp_res.count, out_tdata[21:17]);
          fault_count++;
        end
      end
    end
  end

  // Directed requests. Rows marked typed carry their result by hand: the
  // empty queue after reset, the first pushes and the push onto a full
  // queue. The rest are predicted. Ids zero and all ones are pushed, id zero
  // twice so that find and remove must pick the older of the two, and a
  // handle of zero is found with an ok status.
  directed_row_t directed_rows[25] = '{
    '{OP_POP,    16'h0000, 16'h0000, 1'b1, ST_MISS, 16'h0000, 1'b1, 5'd0},
    '{OP_REMOVE, 16'h0000, 16'hFFFF, 1'b1, ST_MISS, 16'h0000, 1'b1, 5'd0},
    '{OP_FIND,   16'hFFFF, 16'h0000, 1'b1, ST_MISS, 16'h0000, 1'b1, 5'd0},
    '{OP_PUSH,   16'h0000, 16'h0000, 1'b1, ST_OK,   16'h0000, 1'b0, 5'd1},
    '{OP_PUSH,   16'hFFFF, 16'hFFFF, 1'b1, ST_OK,   16'h0000, 1'b0, 5'd2},
    '{OP_PUSH,   16'h0000, 16'h1111, 1'b0, ST_OK,   16'h0000, 1'b0, 5'd0},
    '{OP_PUSH,   16'h8000, 16'h7FFF, 1'b0, ST_OK,   16'h0000, 1'b0, 5'd0},
    '{OP_PUSH,   16'h7FFF, 16'h8000, 1'b0, ST_OK,   16'h0000, 1'b0, 5'd0},
    '{OP_PUSH,   16'h00FF, 16'hFF00, 1'b0, ST_OK,   16'h0000, 1'b0, 5'd0},
    '{OP_PUSH,   16'hFF00, 16'h00FF, 1'b0, ST_OK,   16'h0000, 1'b0, 5'd0},
    '{OP_PUSH,   16'h5555, 16'hAAAA, 1'b0, ST_OK,   16'h0000, 1'b0, 5'd0},
    '{OP_PUSH,   16'hAAAA, 16'h5555, 1'b0, ST_OK,   16'h0000, 1'b0, 5'd0},
    '{OP_PUSH,   16'h0F0F, 16'hF0F0, 1'b0, ST_OK,   16'h0000, 1'b0, 5'd0},
    '{OP_PUSH,   16'hF0F0, 16'h0F0F, 1'b0, ST_OK,   16'h0000, 1'b0, 5'd0},
    '{OP_PUSH,   16'h1234, 16'hFEDC, 1'b0, ST_OK,   16'h0000, 1'b0, 5'd0},
    '{OP_PUSH,   16'hFEDC, 16'h1234, 1'b0, ST_OK,   16'h0000, 1'b0, 5'd0},
    '{OP_PUSH,   16'h0002, 16'hC3C3, 1'b0, ST_OK,   16'h0000, 1'b0, 5'd0},
    '{OP_PUSH,   16'hC3C3, 16'h3C3C, 1'b0, ST_OK,   16'h0000, 1'b0, 5'd0},
    '{OP_PUSH,   16'h3C3C, 16'h0001, 1'b0, ST_OK,   16'h0000, 1'b0, 5'd0},
    '{OP_PUSH,   16'h9999, 16'h6666, 1'b1, ST_FULL, 16'h0000, 1'b0, 5'd16},
    '{OP_FIND,   16'h0000, 16'hFFFF, 1'b0, ST_OK,   16'h0000, 1'b0, 5'd0},
    '{OP_REMOVE, 16'hFFFF, 16'h0000, 1'b0, ST_OK,   16'h0000, 1'b0, 5'd0},
    '{OP_REMOVE, 16'h0000, 16'h0000, 1'b0, ST_OK,   16'h0000, 1'b0, 5'd0},
    '{OP_FIND,   16'h7777, 16'h0000, 1'b0, ST_OK,   16'h0000, 1'b0, 5'd0},
    '{OP_POP,    16'h0000, 16'h0000, 1'b0, ST_OK,   16'h0000, 1'b0, 5'd0}
  };

  initial begin : stimulus
    res_t    typed_res;
    op_t     op;
    int      roll;
    bit      filling;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    rst_n          = 1'b0;
    fault_count    = 0;
    cycle_count    = 0;
    stall_requests = 0;
    results_checked = 0;
    send_idle_pct  = 25;
    recv_idle_pct  = 60;
    foreach (op_tally[i]) op_tally[i] = 0;
    foreach (status_tally[i]) status_tally[i] = 0;

    // Reset is held low from the start and released on a falling edge.
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      typed_res.status = directed_rows[i].status;
      typed_res.handle = directed_rows[i].handle;
      typed_res.empty  = directed_rows[i].empty;
      typed_res.count  = directed_rows[i].count;
      offer_request(directed_rows[i].op, directed_rows[i].id, directed_rows[i].hnd,
                    directed_rows[i].typed, typed_res);
    end

    // Three passes of random requests: sender idling a quarter of the time
    // and receiver more than half, then the reverse, then no idling at all.
    // The mix swings between filling and draining so that the queue runs
    // from empty to full and back many times.
    for (int pass = 0; pass < 3; pass++) begin
      send_idle_pct = (pass == 0) ? 25 : (pass == 1) ? 60 : 0;
      recv_idle_pct = (pass == 0) ? 60 : (pass == 1) ? 25 : 0;
      filling = 1'b1;
      for (int n = 0; n < ITEMS_PER_PASS; n++) begin
        if (n % 40 == 0) filling = (shadow_ids.size() < CAPACITY / 2);
        // Halfway through the last pass the receiver holds off for a long
        // stretch while requests keep coming, so the block backs up.
        if (pass == 2 && n == ITEMS_PER_PASS / 2) stall_requests++;
        roll = $urandom_range(99);
        if (filling)
          op = (roll < 55) ? OP_PUSH : (roll < 65) ? OP_POP : (roll < 85) ? OP_REMOVE : OP_FIND;
        else
          op = (roll < 20) ? OP_PUSH : (roll < 45) ? OP_POP : (roll < 80) ? OP_REMOVE : OP_FIND;
        offer_request(op, pick_id(op == OP_REMOVE || op == OP_FIND), HND_W'($urandom),
                      1'b0, typed_res);
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;

    // Wait for the last result, then a little longer to catch any stray one.
    wait (results_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Requests: %0d push, %0d pop head, %0d remove by id, %0d find by id.",
             op_tally[OP_PUSH], op_tally[OP_POP], op_tally[OP_REMOVE], op_tally[OP_FIND]);
    $display("Results checked: %0d (%0d ok, %0d not found or empty, %0d refused as full).",
             results_checked, status_tally[ST_OK], status_tally[ST_MISS],
             status_tally[ST_FULL]);
    if (fault_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
